// File: rtl/core/key_value_table_core_assert.svh
// Assertion macros used by the key/value table checker.
`ifndef KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define KEY_VALUE_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/kvt_pkg.sv
// Shared types and codes of the key/value table core.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_DONE  = 5'b10000
  } kvt_state_t;

  // Outcome of one table scan.
  typedef struct packed {
    logic hit;
    logic has_free;
  } scan_flags_t;

endpackage

// File: rtl/core/kvt_req_if.sv
// Request channel of the key/value table core.
`timescale 1ns / 1ps

interface kvt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] req_key;
  logic [31:0]        req_value;

  modport source (output valid, output opcode, output req_key, output req_value,
                  input ready);
  modport sink (input valid, input opcode, input req_key, input req_value,
                output ready);
endinterface

// File: rtl/core/kvt_rsp_if.sv
// Result channel of the key/value table core.
`timescale 1ns / 1ps

interface kvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input read_value, input status, input entry_count,
                output ready);
endinterface

// File: rtl/core/kvt_store.sv
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps

module kvt_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int WORD_W = 65
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/kvt_match.sv
// Shared key compare unit: tracks the matching slot and the first free slot.
`timescale 1ns / 1ps

module kvt_match import kvt_pkg::*; #(
  parameter int IDX_W       = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   cmp_en,
  input  logic [IDX_W-1:0]       cmp_idx,
  input  logic                   entry_valid,
  input  logic [KEY_W-1:0]       entry_key,
  input  logic [VALUE_WIDTH-1:0] entry_value,
  input  logic [KEY_W-1:0]       key,
  output scan_flags_t            flags,
  output logic [IDX_W-1:0]       hit_idx,
  output logic [IDX_W-1:0]       free_idx,
  output logic [VALUE_WIDTH-1:0] hit_value
);

  logic is_hit;
  logic is_free;

  assign is_hit  = cmp_en && entry_valid && (entry_key == key);
  assign is_free = cmp_en && !entry_valid;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else begin
      if (is_hit && !flags.hit) begin
        flags.hit <= 1'b1;
      end
      if (is_free && !flags.has_free) begin
        flags.has_free <= 1'b1;
      end
    end
  end

  // Capture the slot only on the first hit and the first free slot.
  always_ff @(posedge clk) begin
    if (is_hit && !flags.hit) begin
      hit_idx   <= cmp_idx;
      hit_value <= entry_value;
    end
    if (is_free && !flags.has_free) begin
      free_idx <= cmp_idx;
    end
  end

endmodule

// File: rtl/core/key_value_table_core.sv
// Key/value table core: sequencer, slot memory and shared compare unit.
`timescale 1ns / 1ps

// A bounded table of CAPACITY slots, each holding a 32-bit key and a value of
// VALUE_WIDTH bits. Each request inserts (or updates), removes or looks up one
// key; every request returns exactly one result with the value found on a
// lookup hit (zero otherwise), a status (ok, key not found, table full) and
// the entry count after the request, masked to 5 bits. An insert fills the
// lowest free slot. Opcode 3 changes nothing and answers ok. For each request
// the slots are read one per cycle through the single read port of the slot
// memory and compared in a single key comparator, then the done state decides
// and writes the slot back while the result is loaded into the output
// register. The request side is not ready until the block returns to idle.
// The result register decouples the two sides: a result waiting for its
// taker does not block the next request, and only the write-back step waits
// for the result register to empty. After reset the block sweeps all slots
// invalid, one per cycle, and takes the first request once the sweep ends.
module key_value_table_core import kvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  kvt_req_if.sink   req,
  kvt_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = 1 + KEY_W + VALUE_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Sequencer state.
  kvt_state_t       state, state_next;
  logic [IDX_W-1:0] scan_addr, scan_addr_next;
  logic             cmp_pend;
  logic [IDX_W-1:0] cmp_idx;
  logic [CNT_W-1:0] occupied, occupied_next;

  // Request held for the scan.
  logic [OPCODE_W-1:0]    op_q;
  logic [KEY_W-1:0]       key_q;
  logic [VALUE_WIDTH-1:0] val_q;

  // Result register.
  logic                out_valid;
  logic [DATA_W-1:0]   out_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  // Memory ports.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  // Compare unit results.
  scan_flags_t            flags;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [VALUE_WIDTH-1:0] hit_value;

  logic                   accept;
  logic                   load_out;
  logic [DATA_W-1:0]      res_value;
  logic [STATUS_W-1:0]    res_status;
  logic [63:0]            val_wide;
  logic [63:0]            hit_wide;
  logic [31:0]            cnt_wide;

  assign accept    = req.valid && (state == ST_IDLE);
  assign req.ready = (state == ST_IDLE);

  // Keep the incoming value to VALUE_WIDTH bits; read it back zero-extended.
  assign val_wide = {32'b0, req.req_value};
  assign hit_wide = 64'(hit_value);
  assign cnt_wide = 32'(occupied_next);

  kvt_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .WORD_W (WORD_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  kvt_match #(
    .IDX_W       (IDX_W),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .cmp_en      (cmp_pend),
    .cmp_idx     (cmp_idx),
    .entry_valid (mem_rdata[WORD_W-1]),
    .entry_key   (mem_rdata[WORD_W-2 -: KEY_W]),
    .entry_value (mem_rdata[VALUE_WIDTH-1:0]),
    .key         (key_q),
    .flags       (flags),
    .hit_idx     (hit_idx),
    .free_idx    (free_idx),
    .hit_value   (hit_value)
  );

  always_comb begin
    state_next     = state;
    scan_addr_next = scan_addr;
    occupied_next  = occupied;
    mem_we         = 1'b0;
    mem_waddr      = scan_addr;
    mem_wdata      = '0;
    load_out       = 1'b0;
    res_value      = '0;
    res_status     = STAT_OK;
    case (state)
      ST_CLEAR: begin
        // Sweep every slot invalid after reset.
        mem_we = 1'b1;
        if (scan_addr == LAST_IDX) begin
          scan_addr_next = '0;
          state_next     = ST_IDLE;
        end else begin
          scan_addr_next = scan_addr + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          scan_addr_next = '0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue one slot read per cycle; each slot is compared in the cycle after its read.
        if (scan_addr == LAST_IDX) begin
          state_next = ST_LAST;
        end else begin
          scan_addr_next = scan_addr + IDX_W'(1);
        end
      end
      ST_LAST: begin
        // Compare the last slot.
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the result register is free, then write back and answer.
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          case (op_q)
            OP_INSERT: begin
              if (flags.hit) begin
                mem_we    = 1'b1;
                mem_waddr = hit_idx;
                mem_wdata = {1'b1, key_q, val_q};
              end else if (flags.has_free) begin
                mem_we        = 1'b1;
                mem_waddr     = free_idx;
                mem_wdata     = {1'b1, key_q, val_q};
                occupied_next = occupied + CNT_W'(1);
              end else begin
                res_status = STAT_FULL;
              end
            end
            OP_REMOVE: begin
              if (flags.hit) begin
                mem_we        = 1'b1;
                mem_waddr     = hit_idx;
                occupied_next = occupied - CNT_W'(1);
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            OP_LOOKUP: begin
              if (flags.hit) begin
                res_value = hit_wide[DATA_W-1:0];
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_addr <= '0;
      cmp_pend  <= 1'b0;
      occupied  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_addr <= scan_addr_next;
      cmp_pend  <= (state == ST_SCAN);
      occupied  <= occupied_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request held for the scan, result held for the taker.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_addr;
    if (accept) begin
      op_q  <= req.opcode;
      key_q <= $unsigned(req.req_key);
      val_q <= val_wide[VALUE_WIDTH-1:0];
    end
    if (load_out) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_value;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

endmodule

// File: rtl/core/kvt_checker.sv
// Port-level checker for the key/value table core, bound to the top level.
`timescale 1ns / 1ps
`include "key_value_table_core_assert.svh"

module kvt_checker import kvt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [DATA_W-1:0]   read_value,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  entry_count
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

  // A stalled result holds.
  `KVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value) && $stable(status) && $stable(entry_count), "result changed while stalled")

  // The table works on one request at a time.
  `KVT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")

  // Only an answer with ok status carries a value.
  `KVT_ASSERT_SAME(a_value_only_ok, rsp_valid && (status != STAT_OK), read_value == '0, "nonzero value on failed request")

  // Full is reported only with every slot in use.
  `KVT_ASSERT_SAME(a_full_count, rsp_valid && (status == STAT_FULL), entry_count == FULL_COUNT, "full reported below capacity")

endmodule

bind key_value_table_core kvt_checker #(
  .CAPACITY (CAPACITY)
) u_kvt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .read_value  (rsp.read_value),
  .status      (rsp.status),
  .entry_count (rsp.entry_count)
);
